>>> sv/ipv4_port_text_parser_unit_defines.svh
// Assertion macros shared by the checker of the address text parser.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef IPV4_PORT_TEXT_PARSER_UNIT_DEFINES_SVH
`define IPV4_PORT_TEXT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define IPTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define IPTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define IPTP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/iptp_pkg.sv
// Shared constants and the character token type of the address text parser.
// Used by the front stage, the token queue and the back stage.
package iptp_pkg;

  localparam logic [7:0]  CH_DOT      = 8'd46;
  localparam logic [7:0]  CH_COLON    = 8'd58;
  localparam logic [7:0]  CH_ZERO     = 8'd48;
  localparam logic [7:0]  CH_NINE     = 8'd57;
  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [16:0] PORT_MAX    = 17'd65535;
  localparam logic [16:0] PORT_SAT    = 17'd65536;
  localparam int          QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       is_num;
    logic       is_dot;
    logic       is_colon;
    logic       last;
    logic [3:0] dval;
  } token_t;

endpackage

>>> sv/iptp_front.sv
// Front stage: accepts characters and classifies them into registered tokens.
// Depends on iptp_pkg.
module iptp_front import iptp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  input  logic       last,
  output logic       tok_valid,
  input  logic       tok_ready,
  output token_t     tok
);

  token_t cls;

  always_comb begin
    cls.is_num   = (ch >= CH_ZERO) && (ch <= CH_NINE);
    cls.is_dot   = (ch == CH_DOT);
    cls.is_colon = (ch == CH_COLON);
    cls.last     = last;
    cls.dval     = 4'(ch - CH_ZERO);
  end

  assign in_ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (in_ready) begin
      tok_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      tok <= cls;
    end
  end

endmodule

>>> sv/iptp_queue.sv
// Short token queue that decouples the front stage from the back stage.
// Depends on iptp_pkg for the token type and the default depth.
module iptp_queue import iptp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  token_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output token_t pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t            mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/iptp_back.sv
// Back stage: runs the dotted-quad and port parse on tokens and holds the result.
// Depends on iptp_pkg.
module iptp_back import iptp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tok_valid,
  output logic        tok_ready,
  input  token_t      tok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] ip_addr,
  output logic [15:0] port_number
);

  typedef enum logic [2:0] {
    PH_SKIP = 3'd0,
    PH_OCT1 = 3'd1,
    PH_OCT2 = 3'd2,
    PH_OCT3 = 3'd3,
    PH_OCT4 = 3'd4,
    PH_PORT = 3'd5
  } phase_t;

  phase_t       phase, phase_next, ph;
  logic [11:0]  octet_acc, octet_next, oct_mul;
  logic [16:0]  port_acc, port_next, port_sat;
  logic [19:0]  port_mul;
  logic [31:0]  addr_reg, addr_next, addr_shift;
  logic         decided, decided_next;
  logic         oct_ok, act, pop;
  logic         res_fire, res_ok;
  logic [31:0]  res_addr;
  logic [15:0]  res_port;

  assign tok_ready  = !out_valid || out_ready;
  assign pop        = tok_valid && tok_ready;
  assign oct_ok     = (octet_acc <= OCTET_MAX);
  assign oct_mul    = octet_acc * 12'd10 + {8'd0, tok.dval};
  assign port_mul   = {3'd0, port_acc} * 20'd10 + {16'd0, tok.dval};
  assign port_sat   = (port_mul > {3'd0, PORT_SAT}) ? PORT_SAT : port_mul[16:0];
  assign addr_shift = {addr_reg[23:0], octet_acc[7:0]};

  always_comb begin
    phase_next   = phase;
    octet_next   = octet_acc;
    port_next    = port_acc;
    addr_next    = addr_reg;
    decided_next = decided;
    res_fire     = 1'b0;
    res_ok       = 1'b0;
    res_addr     = '0;
    res_port     = '0;
    ph           = phase;
    act          = 1'b0;

    if (!decided) begin
      act = 1'b1;
      if (!(phase inside {PH_OCT1, PH_OCT2, PH_OCT3, PH_OCT4, PH_PORT})) begin
        if (tok.is_num) begin
          ph = PH_OCT1;
        end else begin
          act      = 1'b0;
          res_fire = tok.last;
        end
      end
    end

    if (act) begin
      phase_next = ph;
      unique case (ph)
        PH_OCT1, PH_OCT2, PH_OCT3: begin
          if (tok.is_num && oct_ok) begin
            octet_next = oct_mul;
          end else if (tok.is_dot && oct_ok) begin
            addr_next  = addr_shift;
            octet_next = '0;
            phase_next = (ph == PH_OCT1) ? PH_OCT2 : (ph == PH_OCT2) ? PH_OCT3 : PH_OCT4;
          end else begin
            res_fire     = 1'b1;
            decided_next = 1'b1;
          end
        end
        PH_OCT4: begin
          if (tok.is_num && oct_ok) begin
            octet_next = oct_mul;
          end else if (oct_ok) begin
            addr_next  = addr_shift;
            octet_next = '0;
            if (tok.is_colon) begin
              phase_next = PH_PORT;
            end else begin
              res_fire     = 1'b1;
              res_ok       = 1'b1;
              res_addr     = addr_shift;
              decided_next = 1'b1;
            end
          end else begin
            res_fire     = 1'b1;
            decided_next = 1'b1;
          end
        end
        PH_PORT: begin
          if (tok.is_num) begin
            port_next = port_sat;
          end else begin
            res_fire     = 1'b1;
            res_ok       = (port_acc <= PORT_MAX);
            res_addr     = addr_reg;
            res_port     = port_acc[15:0];
            decided_next = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (tok.last && !decided_next) begin
        res_fire = 1'b1;
        unique case (phase_next)
          PH_OCT4: begin
            res_ok   = (octet_next <= OCTET_MAX);
            res_addr = {addr_next[23:0], octet_next[7:0]};
          end
          PH_PORT: begin
            res_ok   = 1'b1;
            res_addr = addr_next;
            res_port = (port_next <= PORT_MAX) ? port_next[15:0] : 16'd0;
          end
          default: begin
            res_ok = 1'b0;
          end
        endcase
      end
    end

    if (!res_ok) begin
      res_addr = '0;
      res_port = '0;
    end

    if (tok.last) begin
      phase_next   = PH_SKIP;
      octet_next   = '0;
      port_next    = '0;
      addr_next    = '0;
      decided_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SKIP;
      octet_acc <= '0;
      port_acc  <= '0;
      addr_reg  <= '0;
      decided   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        phase     <= phase_next;
        octet_acc <= octet_next;
        port_acc  <= port_next;
        addr_reg  <= addr_next;
        decided   <= decided_next;
      end
      if (pop && res_fire) begin
        out_valid   <= 1'b1;
        ok          <= res_ok;
        ip_addr     <= res_addr;
        port_number <= res_port;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> sv/ipv4_port_text_parser_unit.sv
// Parses IPv4 dotted-quad text with an optional ":port", one character per
// request, and gives one result per string (marked by last on its final
// character). It sustains one character per clock cycle unless the result
// output stalls; the back stage's parse state update, one compare and one
// multiply-by-ten add per character, sets that rate. The character that
// decides a result passes the front register, queue and result register;
// later ones up to the one marked last give no result. The front stage
// classifies characters into a short queue, so either side may stall alone.
module ipv4_port_text_parser_unit import iptp_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [31:0] ip_addr,
  output logic [15:0] port_number
);

  logic   ftok_valid, ftok_ready;
  token_t ftok;
  logic   btok_valid, btok_ready;
  token_t btok;

  iptp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .last      (last),
    .tok_valid (ftok_valid),
    .tok_ready (ftok_ready),
    .tok       (ftok)
  );

  iptp_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (ftok_valid),
    .push_ready (ftok_ready),
    .push_data  (ftok),
    .pop_valid  (btok_valid),
    .pop_ready  (btok_ready),
    .pop_data   (btok)
  );

  iptp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .tok_valid   (btok_valid),
    .tok_ready   (btok_ready),
    .tok         (btok),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .ip_addr     (ip_addr),
    .port_number (port_number)
  );

endmodule

>>> sv/iptp_checker.sv
// Port-level checks of the address text parser, bound to its top level.
// Depends on ipv4_port_text_parser_unit_defines.svh.
`include "ipv4_port_text_parser_unit_defines.svh"

module iptp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  ch,
  input logic        last,
  input logic        out_valid,
  input logic        out_ready,
  input logic        ok,
  input logic [31:0] ip_addr,
  input logic [15:0] port_number
);

  `IPTP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(ok) && $stable(ip_addr) && $stable(port_number), "stalled result changed")
  `IPTP_ASSERT_NOW(a_fail_zero, clk, rst, out_valid && !ok, ip_addr == 32'd0 && port_number == 16'd0, "failed result carries nonzero fields")
  `IPTP_ASSERT_ALWAYS(a_reset_idle, clk, rst, !out_valid && in_ready, "block not idle after reset")

endmodule

bind ipv4_port_text_parser_unit iptp_checker u_iptp_checker (.*);
